>>> src/assert_macros.svh
// Assertion macros used by the checker file bssf_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is applied.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/bssf_pkg.sv
package bssf_pkg;

  localparam logic [7:0]  LEVEL_MAX             = 8'd100;
  localparam logic [7:0]  NEAR_FULL_CHARGING    = 8'd95;
  localparam logic [7:0]  NEAR_FULL_DISCHARGING = 8'd90;
  localparam logic [2:0]  BAD_RUN_LIMIT         = 3'd5;
  localparam logic [6:0]  LOW_GUARD             = 7'd2;
  localparam logic [6:0]  ONE_BELOW_FULL        = 7'd99;
  localparam logic [6:0]  LEVEL_RESET           = 7'd2;
  localparam logic [15:0] TICK_MAX              = 16'hFFFF;

  localparam logic [15:0] UP_STEP_RESET    = 16'd420;
  localparam logic [15:0] DOWN_STEP_RESET  = 16'd60;
  localparam logic [15:0] ZERO_RESET_RESET = 16'd1800;

  typedef enum logic [1:0] {
    CFG_UP_STEP    = 2'd0,
    CFG_DOWN_STEP  = 2'd1,
    CFG_ZERO_RESET = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] up_step_ticks;
    logic [15:0] down_step_ticks;
    logic [15:0] zero_reset_ticks;
  } cfg_t;

  typedef struct packed {
    logic [6:0] level_percent;
    logic       reset_request;
    logic       reading_rejected;
  } res_t;

  function automatic logic [15:0] tick_inc(input logic [15:0] t);
    return (t == TICK_MAX) ? TICK_MAX : t + 16'd1;
  endfunction

endpackage

>>> src/bssf_cfg.sv
module bssf_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [15:0]    cfg_data_i,
  output bssf_pkg::cfg_t cfg_o
);
  import bssf_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_UP_STEP:    cfg_d.up_step_ticks    = cfg_data_i;
        CFG_DOWN_STEP:  cfg_d.down_step_ticks  = cfg_data_i;
        CFG_ZERO_RESET: cfg_d.zero_reset_ticks = cfg_data_i;
        default: ; // unused index: drop the transfer
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.up_step_ticks    <= UP_STEP_RESET;
      cfg_q.down_step_ticks  <= DOWN_STEP_RESET;
      cfg_q.zero_reset_ticks <= ZERO_RESET_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/bssf_datapath.sv
module bssf_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     soc_i,
  input  logic           chg_i,
  input  bssf_pkg::cfg_t cfg_i,
  output bssf_pkg::res_t res_o
);
  import bssf_pkg::*;

  logic [6:0]  level_q, level_d;
  logic [2:0]  bad_run_q, bad_run_d;
  logic [15:0] near_ticks_q, near_ticks_d;
  logic        forced_full_q, forced_full_d;
  logic [15:0] zero_ticks_q, zero_ticks_d;
  logic        qs_done_q, qs_done_d;

  logic        rejected;
  logic [2:0]  bad_run_inc;
  logic [7:0]  cap8;
  logic [6:0]  cap_up;
  logic [6:0]  cap_down;
  logic        against_dir;
  logic        keep;
  logic [7:0]  soc_s;
  logic [7:0]  soc_f;
  logic [15:0] near_inc;
  logic [15:0] zero_inc;
  logic        req;

  assign rejected    = soc_i > LEVEL_MAX;
  assign bad_run_inc = bad_run_q + 3'd1;
  assign cap8        = {1'b0, level_q};
  assign cap_up      = (cap8 < LEVEL_MAX) ? level_q + 7'd1 : LEVEL_MAX[6:0];
  assign cap_down    = (level_q != 7'd0) ? level_q - 7'd1 : 7'd0;
  assign near_inc    = tick_inc(near_ticks_q);
  assign zero_inc    = tick_inc(zero_ticks_q);

  // one-step move against the charging direction
  assign against_dir = (chg_i && (({1'b0, soc_i} + 9'd1) == {2'b00, level_q})) ||
                       (!chg_i && (soc_i == cap8 + 8'd1));
  assign keep = ((soc_i == 8'd0) && (level_q <= LOW_GUARD)) ||
                ((soc_i == LEVEL_MAX) && (level_q == ONE_BELOW_FULL));
  assign soc_s = (against_dir && !keep) ? cap8 : soc_i;

  always_comb begin
    level_d       = level_q;
    bad_run_d     = bad_run_q;
    near_ticks_d  = near_ticks_q;
    forced_full_d = forced_full_q;
    zero_ticks_d  = zero_ticks_q;
    qs_done_d     = qs_done_q;
    soc_f         = soc_s;
    req           = 1'b0;

    if (rejected) begin
      bad_run_d = bad_run_inc;
      if (bad_run_inc > BAD_RUN_LIMIT) begin
        req       = 1'b1;
        bad_run_d = 3'd0;
      end
    end else begin
      bad_run_d = 3'd0;

      // creep near full
      if (chg_i && soc_s >= NEAR_FULL_CHARGING && soc_s <= cap8) begin
        if (near_inc >= cfg_i.up_step_ticks) begin
          soc_f         = {1'b0, cap_up};
          forced_full_d = 1'b1;
          near_ticks_d  = 16'd0;
        end else begin
          soc_f        = cap8;
          near_ticks_d = near_inc;
        end
      end else if (!chg_i && soc_s <= cap8 && soc_s >= NEAR_FULL_DISCHARGING &&
                   forced_full_q) begin
        if (near_inc >= cfg_i.down_step_ticks) begin
          near_ticks_d = 16'd0;
          if (soc_s >= {1'b0, cap_down}) begin
            forced_full_d = 1'b0;
          end else begin
            soc_f = {1'b0, cap_down};
          end
        end else begin
          soc_f        = cap8;
          near_ticks_d = near_inc;
        end
      end else begin
        near_ticks_d = 16'd0;
      end

      // quick-start on a persistent zero while charging
      if (chg_i && soc_f == 8'd0) begin
        zero_ticks_d = zero_inc;
        if (zero_inc >= cfg_i.zero_reset_ticks && !qs_done_q) begin
          req          = 1'b1;
          qs_done_d    = 1'b1;
          zero_ticks_d = 16'd0;
        end
      end else if (qs_done_q && !chg_i) begin
        qs_done_d = 1'b0;
      end

      level_d = soc_f[6:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q       <= LEVEL_RESET;
      bad_run_q     <= 3'd0;
      near_ticks_q  <= 16'd0;
      forced_full_q <= 1'b0;
      zero_ticks_q  <= 16'd0;
      qs_done_q     <= 1'b0;
    end else if (step_i) begin
      level_q       <= level_d;
      bad_run_q     <= bad_run_d;
      near_ticks_q  <= near_ticks_d;
      forced_full_q <= forced_full_d;
      zero_ticks_q  <= zero_ticks_d;
      qs_done_q     <= qs_done_d;
    end
  end

  assign res_o.level_percent    = level_d;
  assign res_o.reset_request    = req;
  assign res_o.reading_rejected = rejected;

endmodule

>>> src/battery_soc_smoothing_filter_unit.sv
// An input transfer is registered in the s1 stage, then its result in the output register.
// Throughput: one reading per cycle unless stalled; state updates in a single pass.
// Input stalls only while a result is held in the output register by out_stall_i.
// Reset (rst_ni, async, active low): level 2, counters and flags cleared,
// step registers 420 / 60 / 1800, pipeline empty.
module battery_soc_smoothing_filter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  soc_raw_i,
  input  logic        charger_online_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  level_percent_o,
  output logic        reset_request_o,
  output logic        reading_rejected_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import bssf_pkg::*;

  logic       s1_valid_q;
  logic [7:0] s1_soc_q;
  logic       s1_chg_q;
  logic       advance;
  logic       in_ready;
  logic       step;
  logic       out_valid_q;
  res_t       out_q;
  res_t       res;
  cfg_t       cfg;

  assign advance  = !out_valid_q || !out_stall_i;
  assign in_ready = !s1_valid_q || advance;
  assign step     = s1_valid_q && advance;

  assign in_stall_o  = !in_ready;
  assign cfg_ready_o = 1'b1;

  bssf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bssf_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .soc_i  (s1_soc_q),
    .chg_i  (s1_chg_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      s1_soc_q <= soc_raw_i;
      s1_chg_q <= charger_online_i;
    end
  end

  // hold the result while the far side stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign level_percent_o    = out_q.level_percent;
  assign reset_request_o    = out_q.reset_request;
  assign reading_rejected_o = out_q.reading_rejected;

endmodule

>>> src/bssf_checker.sv
`include "assert_macros.svh"

module bssf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [6:0]  level_percent_o,
  input logic        reset_request_o,
  input logic        reading_rejected_o
);

  // reported level never leaves the percentage range
  `ASSERT_IMPL(a_level_range, clk_i, rst_ni, out_valid_o, level_percent_o <= 7'd100)

  // a quick-start reset is only requested at a reported level of zero
  `ASSERT_IMPL(a_quickstart_zero, clk_i, rst_ni,
               out_valid_o && reset_request_o && !reading_rejected_o,
               level_percent_o == 7'd0)

  // input backs up only behind a held result
  `ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
               out_valid_o && $stable(level_percent_o) && $stable(reset_request_o) &&
               $stable(reading_rejected_o))

endmodule

bind battery_soc_smoothing_filter_unit bssf_checker u_bssf_checker (.*);
